[design/bmpq_pkg.sv]
// Shared types and constants for the bounded max-priority queue.
// No dependencies; every other file in the design imports this package.
package bmpq_pkg;

  localparam int DEPTH   = 16;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = $clog2(DEPTH + 1);
  localparam int CAP_W   = 5;
  localparam int CMP_W   = (COUNT_W > CAP_W) ? COUNT_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(4);

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [COUNT_W-1:0]        count_t;
  typedef logic [CAP_W-1:0]          cap_t;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_e;

  // What every cell does to its entry in the current cycle.
  typedef enum logic [1:0] {
    OP_HOLD       = 2'd0,
    OP_PUSH       = 2'd1,
    OP_PUSH_EVICT = 2'd2,
    OP_POP        = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    value_t   value;
  } cell_cmd_t;

endpackage

[design/bmpq_if.sv]
// Valid/ready channel interfaces for commands and results.
// Depends on bmpq_pkg for payload types.
interface bmpq_in_if import bmpq_pkg::*; ();
  logic   valid;
  logic   ready;
  cmd_e   command;
  value_t value;

  modport source (output valid, command, value, input ready);
  modport sink   (input valid, command, value, output ready);
endinterface

interface bmpq_out_if import bmpq_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t top_value;
  logic   is_empty;
  count_t entry_count;
  logic   evicted;

  modport source (output valid, top_value, is_empty, entry_count, evicted, input ready);
  modport sink   (input valid, top_value, is_empty, entry_count, evicted, output ready);
endinterface

[design/bmpq_cell.sv]
// One slot of the sorted chain: holds an entry and updates it from its neighbors.
// Depends on bmpq_pkg.
module bmpq_cell import bmpq_pkg::*; (
  input  logic      clk_i,
  input  cell_cmd_t cmd_i,
  input  logic      occ_i,          // slot holds a live entry
  input  logic      head_i,         // slot is the front of the chain
  input  value_t    left_entry_i,
  input  logic      left_after_i,   // new value sorts behind the left slot
  input  value_t    right_entry_i,
  input  logic      right_after_i,  // new value sorts behind the right slot
  output value_t    entry_o,
  output logic      after_o
);

  value_t entry_q, entry_d;

  always_comb begin
    // Ties keep the new value behind the stored one.
    after_o = occ_i && !(cmd_i.value > entry_q);
    entry_d = entry_q;
    unique case (cmd_i.op)
      OP_HOLD: entry_d = entry_q;
      OP_PUSH: begin
        if (after_o) entry_d = entry_q;
        else if (left_after_i) entry_d = cmd_i.value;
        else entry_d = left_entry_i;
      end
      OP_PUSH_EVICT: begin
        // Chain shifts toward the head, then the value drops into its slot.
        if (right_after_i) entry_d = right_entry_i;
        else if (after_o || head_i) entry_d = cmd_i.value;
        else entry_d = entry_q;
      end
      OP_POP: entry_d = right_entry_i;
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

[design/bounded_max_priority_queue_top.sv]
// Top level of the bounded max-priority queue: control, count and the cell chain.
// Depends on bmpq_pkg, bmpq_if (channel interfaces) and bmpq_cell.
//
//   channel  dir  handshake           word
//   in_i     in   valid/ready         command, value
//   out_o    out  valid/ready         top_value, is_empty, entry_count, evicted
//   cfg      in   cfg_we_i (no wait)  cfg_wdata_i -> capacity
//
// Every cell updates its slot in the accepting cycle, so the result word is
// valid the next cycle and a new command can be taken in the same cycle the
// previous result leaves. The command path is set by one signed compare per
// cell plus a count compare against capacity. Reset clears count (queue
// empty), result valid and the evicted flag, and restores capacity to 4;
// entries hold no reset value. A stalled result holds the input off.
module bounded_max_priority_queue_top import bmpq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  cap_t        cfg_wdata_i,
  bmpq_in_if.sink     in_i,
  bmpq_out_if.source  out_o
);

  cap_t      cap_q;
  count_t    count_q, count_d;
  logic      out_valid_q, out_valid_d;
  logic      evicted_q, evicted_d;
  logic      accept;
  logic      full;
  logic [CMP_W-1:0] cap_ext, eff_cap;
  cell_cmd_t cmd;

  value_t entry [DEPTH];
  logic   after [DEPTH];
  logic   occ   [DEPTH];

  // Capacity register; zero reads as one and large values saturate to DEPTH.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  assign cap_ext = CMP_W'(cap_q);
  assign eff_cap = (cap_q == '0) ? CMP_W'(1) :
                   (cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;
  assign full    = CMP_W'(count_q) >= eff_cap;

  // Take a command whenever the result slot is free or draining this cycle.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    cmd.value   = in_i.value;
    cmd.op      = OP_HOLD;
    count_d     = count_q;
    evicted_d   = evicted_q;
    out_valid_d = out_valid_q;
    if (out_o.ready) out_valid_d = 1'b0;
    if (accept) begin
      out_valid_d = 1'b1;
      evicted_d   = 1'b0;
      unique case (in_i.command)
        CMD_PUSH: begin
          if (full) begin
            cmd.op    = OP_PUSH_EVICT;
            evicted_d = 1'b1;
          end else begin
            cmd.op  = OP_PUSH;
            count_d = count_q + count_t'(1);
          end
        end
        CMD_POP: begin
          cmd.op = OP_POP;
          if (count_q != '0) count_d = count_q - count_t'(1);
        end
        default: cmd.op = OP_HOLD;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
      evicted_q   <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      evicted_q   <= evicted_d;
    end
  end

  // Sorted chain, largest entry in cell 0.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam count_t Idx = count_t'(i);
    value_t left_entry, right_entry;
    logic   left_after, right_after;

    assign occ[i] = Idx < count_q;

    if (i == 0) begin : g_head
      assign left_entry = '0;
      assign left_after = 1'b1;
    end else begin : g_mid
      assign left_entry = entry[i-1];
      assign left_after = after[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_entry = '0;
      assign right_after = 1'b0;
    end else begin : g_body
      assign right_entry = entry[i+1];
      assign right_after = after[i+1];
    end

    bmpq_cell u_cell (
      .clk_i         (clk_i),
      .cmd_i         (cmd),
      .occ_i         (occ[i]),
      .head_i        (i == 0),
      .left_entry_i  (left_entry),
      .left_after_i  (left_after),
      .right_entry_i (right_entry),
      .right_after_i (right_after),
      .entry_o       (entry[i]),
      .after_o       (after[i])
    );
  end

  // Result word reflects the state left by the last accepted command.
  assign out_o.valid       = out_valid_q;
  assign out_o.top_value   = (count_q == '0) ? '0 : entry[0];
  assign out_o.is_empty    = (count_q == '0);
  assign out_o.entry_count = count_q;
  assign out_o.evicted     = evicted_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= count_t'(DEPTH))
    else $error("count exceeds depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op == OP_PUSH_EVICT |=> count_q == $past(count_q) && evicted_q)
    else $error("evicting push changed count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op == OP_POP && count_q != '0 |=> count_q == $past(count_q) - count_t'(1))
    else $error("pop did not drop one entry");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q >= count_t'(2) |-> entry[0] >= entry[1])
    else $error("chain head out of order");

endmodule
